FILE: design/rbtp_pkg.sv
// ---------------------------------------------------------------------------
// rbtp_pkg: shared types and constants for the rotated box table
// Item kinds, datapath operation codes and the per-box collide sequence.
// ---------------------------------------------------------------------------
package rbtp_pkg;

  localparam int MAX_BOXES_DEF = 16;
  localparam int POS_W         = 24;
  localparam int CRD_W         = 28;
  localparam int HALF_W        = 15;
  localparam int ANG_W         = 12;
  localparam int SCL_W         = 14;
  localparam int RAD_W         = 16;
  localparam int SLOT_W        = 4;
  localparam int KIND_W        = 3;
  localparam int STEP_W        = 4;

  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_COLLIDE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ARM     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TRIG    = 3'd5;

  localparam logic [ANG_W-1:0]  SPIN_STEP     = 12'd8;
  localparam logic [25:0]       TRIGGER_RANGE = 26'd500;
  localparam logic [STEP_W-1:0] COL_LAST      = 4'd15;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ADD, OP_FULL, OP_ARM, OP_TRIG0, OP_RD, OP_TICKW, OP_TCHK,
    OP_HW, OP_HD, OP_SQS, OP_SQC, OP_INS, OP_INC, OP_YS, OP_YC,
    OP_BW0, OP_BW1, OP_BD0, OP_BD1, OP_BND, OP_PEN, OP_PUSH, OP_OUTXY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic fresh;
  } dp_stat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
    logic [ANG_W-1:0]        ang;
    logic [SCL_W-1:0]        scl;
  } box_t;

  // One box of a collide walk takes sixteen steps.
  function automatic dp_op_t col_op(input logic [STEP_W-1:0] step);
    dp_op_t op;
    case (step)
      4'd0:    op = OP_RD;
      4'd1:    op = OP_HW;
      4'd2:    op = OP_HD;
      4'd3:    op = OP_SQS;
      4'd4:    op = OP_SQC;
      4'd5:    op = OP_INS;
      4'd6:    op = OP_INC;
      4'd7:    op = OP_YS;
      4'd8:    op = OP_YC;
      4'd9:    op = OP_BW0;
      4'd10:   op = OP_BW1;
      4'd11:   op = OP_BD0;
      4'd12:   op = OP_BD1;
      4'd13:   op = OP_BND;
      4'd14:   op = OP_PEN;
      4'd15:   op = OP_PUSH;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

FILE: design/rbtp_in_if.sv
// ---------------------------------------------------------------------------
// rbtp_in_if: command channel
// Valid/ready channel that carries one command word.
// ---------------------------------------------------------------------------
interface rbtp_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_z;
  logic [11:0]        angle;
  logic [13:0]        scale;
  logic [15:0]        radius;
  logic               button_held;

  modport source (output valid, kind, pos_x, pos_z, angle, scale, radius, button_held,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_z, angle, scale, radius, button_held,
                output ready);
endinterface

FILE: design/rbtp_out_if.sv
// ---------------------------------------------------------------------------
// rbtp_out_if: result channel
// Valid/ready channel that carries one result word.
// ---------------------------------------------------------------------------
interface rbtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pushed_x;
  logic signed [23:0] pushed_z;
  logic [3:0]         slot_index;
  logic               table_full;
  logic               save_requested;

  modport source (output valid, pushed_x, pushed_z, slot_index, table_full,
                  save_requested, input ready);
  modport sink (input valid, pushed_x, pushed_z, slot_index, table_full,
                save_requested, output ready);
endinterface

FILE: design/rotated_box_table_pushout.sv
// ---------------------------------------------------------------------------
// rotated_box_table_pushout: rotated box obstacle table with circle push-out
// Keeps up to MAX_BOXES boxes and answers add, clear, tick, collide, arm and
// trigger commands, one result word per command word.
// ---------------------------------------------------------------------------
//  port     direction  handshake       carries
//  in_ch    sink       valid/ready     command word
//  out_ch   source     valid/ready     result word
//  cfg_*    input      write enable    half_width (0), half_depth (1)
//
// Add, clear, arm, unused kinds and a trigger without a fresh press pass
// from S_EXEC to S_DONE. Tick, a fresh trigger and collide walk the stored
// boxes in S_WALK; each box is one registered table read and a write-back
// (tick), a range check (trigger) or the shared multiply steps (collide).
// One command is in flight at a time; the next word can be accepted in the
// cycle after the result is taken. Reset is synchronous: the table is empty
// and the button reads as held. A stalled result holds until taken.
module rotated_box_table_pushout #(
  parameter int MAX_BOXES = rbtp_pkg::MAX_BOXES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rbtp_in_if.sink                     in_ch,
  rbtp_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rbtp_pkg::HALF_W-1:0] cfg_data
);
  import rbtp_pkg::*;

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] addr;

  rbtp_ctrl #(.MAX_BOXES(MAX_BOXES), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .addr      (addr),
    .stat      (stat)
  );

  rbtp_dp #(.MAX_BOXES(MAX_BOXES), .AW(AW)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .addr           (addr),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pos_x       (in_ch.pos_x),
    .in_pos_z       (in_ch.pos_z),
    .in_angle       (in_ch.angle),
    .in_scale       (in_ch.scale),
    .in_radius      (in_ch.radius),
    .in_button_held (in_ch.button_held),
    .res_x          (out_ch.pushed_x),
    .res_z          (out_ch.pushed_z),
    .res_slot       (out_ch.slot_index),
    .res_full       (out_ch.table_full),
    .res_save       (out_ch.save_requested)
  );
endmodule

FILE: design/rbtp_dp.sv
// ---------------------------------------------------------------------------
// rbtp_dp: box table datapath
// Box memory, sine and bound arithmetic, push-out and the result registers.
// ---------------------------------------------------------------------------
module rbtp_dp #(
  parameter int MAX_BOXES = rbtp_pkg::MAX_BOXES_DEF,
  parameter int AW        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rbtp_pkg::dp_cmd_t            cmd,
  input  logic [AW-1:0]                addr,
  output rbtp_pkg::dp_stat_t           stat,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [rbtp_pkg::HALF_W-1:0]  cfg_data,
  input  logic signed [23:0]           in_pos_x,
  input  logic signed [23:0]           in_pos_z,
  input  logic [11:0]                  in_angle,
  input  logic [13:0]                  in_scale,
  input  logic [15:0]                  in_radius,
  input  logic                         in_button_held,
  output logic signed [23:0]           res_x,
  output logic signed [23:0]           res_z,
  output logic [3:0]                   res_slot,
  output logic                         res_full,
  output logic                         res_save
);
  import rbtp_pkg::*;

  box_t mem [MAX_BOXES];
  box_t mq_r;

  logic [HALF_W-1:0] hw_cfg_r, hd_cfg_r;
  logic signed [POS_W-1:0] px_r, pz_r;
  logic [ANG_W-1:0] ang_r;
  logic [SCL_W-1:0] scl_r;
  logic [RAD_W-1:0] rad_r;
  logic held_r, was_held_r;

  logic signed [CRD_W-1:0] cx_r, cz_r;
  logic [16:0] hw_r, hd_r;
  logic [14:0] sqs_r, sqc_r, ins_r, inc_r;
  logic [12:0] ys_r, yc_r;
  logic [29:0] acc_r;
  logic [18:0] bw_r, bd_r;
  logic signed [CRD_W-1:0] minx_r, maxx_r, minz_r, maxz_r;
  logic signed [CRD_W-1:0] pl_r, pr_r, pf_r, pb_r;
  logic inside_r;

  // Combinational terms for the current operation
  logic [28:0] m_scl;
  logic signed [10:0] v_s, v_c, v_sel;
  logic signed [21:0] v_sq;
  logic [14:0] sq_sel, in_sel;
  logic [25:0] m_in;
  logic [29:0] m_y;
  logic signed [13:0] y_val;
  logic [12:0] y_abs;
  logic [12:0] y_a, y_b;
  logic [30:0] m_b;
  logic [30:0] b_sum;
  logic [CRD_W-1:0] ext_x, ext_z;
  logic signed [CRD_W-1:0] bx, bz;
  logic signed [CRD_W-1:0] dx, dz, m;
  logic signed [24:0] tdx, tdz;
  logic [24:0] tax, taz;
  logic [25:0] tdist;
  box_t tick_box;

  assign stat.fresh = held_r & ~was_held_r;

  always_comb begin
    m_scl  = 29'((cmd.op == OP_HW) ? hw_cfg_r : hd_cfg_r) * 29'(mq_r.scl);
    v_c    = $signed(mq_r.ang[10:0]);
    v_s    = $signed({~mq_r.ang[10], mq_r.ang[9:0]});
    v_sel  = (cmd.op == OP_SQS) ? v_s : v_c;
    v_sq   = v_sel * v_sel;
    sq_sel = (cmd.op == OP_INS || cmd.op == OP_YS) ? sqs_r : sqc_r;
    in_sel = (cmd.op == OP_YS) ? ins_r : inc_r;
    m_in   = 26'(sq_sel) * 26'd3516;
    m_y    = 30'(sq_sel) * 30'(in_sel);
    y_val  = 14'sd4096 - $signed({1'b0, m_y[28:16]});
    y_abs  = y_val[13] ? 13'(-y_val) : 13'(y_val);
    // BW uses hw*cos + hd*sin, BD uses hw*sin + hd*cos.
    y_a    = (cmd.op == OP_BW0) ? yc_r : ys_r;
    y_b    = (cmd.op == OP_BW1) ? ys_r : yc_r;
    m_b    = 31'(hd_r) * 31'(y_b);
    b_sum  = 31'(acc_r) + m_b;
    ext_x  = CRD_W'(bw_r) + CRD_W'(rad_r);
    ext_z  = CRD_W'(bd_r) + CRD_W'(rad_r);
    bx     = {{(CRD_W-POS_W){mq_r.x[POS_W-1]}}, mq_r.x};
    bz     = {{(CRD_W-POS_W){mq_r.z[POS_W-1]}}, mq_r.z};
    // Least penetration wins; ties keep the earlier side.
    m  = pl_r;
    dx = -pl_r;
    dz = '0;
    if (pr_r < m) begin
      m  = pr_r;
      dx = pr_r;
      dz = '0;
    end
    if (pf_r < m) begin
      m  = pf_r;
      dx = '0;
      dz = -pf_r;
    end
    if (pb_r < m) begin
      dx = '0;
      dz = pb_r;
    end
    tdx   = {px_r[POS_W-1], px_r} - {mq_r.x[POS_W-1], mq_r.x};
    tdz   = {pz_r[POS_W-1], pz_r} - {mq_r.z[POS_W-1], mq_r.z};
    tax   = tdx[24] ? 25'(-tdx) : 25'(tdx);
    taz   = tdz[24] ? 25'(-tdz) : 25'(tdz);
    tdist = 26'(tax) + 26'(taz);
    tick_box     = mq_r;
    tick_box.ang = mq_r.ang + SPIN_STEP;
  end

  // Table memory: one access per cycle, either a write or a registered read.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ADD) begin
      mem[addr] <= '{x: px_r, z: pz_r, ang: ang_r, scl: scl_r};
    end else if (cmd.op == OP_TICKW) begin
      mem[addr] <= tick_box;
    end
    if (cmd.op == OP_RD) begin
      mq_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_cfg_r   <= '0;
      hd_cfg_r   <= '0;
      was_held_r <= 1'b1;
    end else begin
      if (cfg_we && !cfg_index) hw_cfg_r <= cfg_data;
      if (cfg_we && cfg_index)  hd_cfg_r <= cfg_data;
      if (cmd.op == OP_ARM || cmd.op == OP_TRIG0) was_held_r <= held_r;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        px_r     <= in_pos_x;
        pz_r     <= in_pos_z;
        ang_r    <= in_angle;
        scl_r    <= in_scale;
        rad_r    <= in_radius;
        held_r   <= in_button_held;
        cx_r     <= {{(CRD_W-POS_W){in_pos_x[POS_W-1]}}, in_pos_x};
        cz_r     <= {{(CRD_W-POS_W){in_pos_z[POS_W-1]}}, in_pos_z};
        res_x    <= '0;
        res_z    <= '0;
        res_slot <= '0;
        res_full <= 1'b0;
        res_save <= 1'b0;
      end
      OP_ADD:   res_slot <= SLOT_W'(addr);
      OP_FULL:  res_full <= 1'b1;
      OP_TCHK:  if (tdist < TRIGGER_RANGE) res_save <= 1'b1;
      OP_HW:    hw_r <= m_scl[28:12];
      OP_HD:    hd_r <= m_scl[28:12];
      OP_SQS:   sqs_r <= v_sq[20:6];
      OP_SQC:   sqc_r <= v_sq[20:6];
      OP_INS:   ins_r <= 15'd19900 - 15'(m_in[25:14]);
      OP_INC:   inc_r <= 15'd19900 - 15'(m_in[25:14]);
      OP_YS:    ys_r <= y_abs;
      OP_YC:    yc_r <= y_abs;
      OP_BW0, OP_BD0: acc_r <= 30'(hw_r) * 30'(y_a);
      OP_BW1:   bw_r <= b_sum[30:12];
      OP_BD1:   bd_r <= b_sum[30:12];
      OP_BND: begin
        minx_r <= bx - $signed(ext_x);
        maxx_r <= bx + $signed(ext_x);
        minz_r <= bz - $signed(ext_z);
        maxz_r <= bz + $signed(ext_z);
      end
      OP_PEN: begin
        inside_r <= (cx_r > minx_r) && (cx_r < maxx_r) &&
                    (cz_r > minz_r) && (cz_r < maxz_r);
        pl_r <= cx_r - minx_r;
        pr_r <= maxx_r - cx_r;
        pf_r <= cz_r - minz_r;
        pb_r <= maxz_r - cz_r;
      end
      OP_PUSH: begin
        if (inside_r) begin
          cx_r <= cx_r + dx;
          cz_r <= cz_r + dz;
        end
      end
      OP_OUTXY: begin
        res_x <= cx_r[POS_W-1:0];
        res_z <= cz_r[POS_W-1:0];
      end
      default: ;
    endcase
  end

  // A push lands the player on a bound edge, never deeper inside.
  a_push_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUSH && inside_r) |=>
      (cx_r == $past(minx_r) || cx_r == $past(maxx_r) ||
       cz_r == $past(minz_r) || cz_r == $past(maxz_r)))
    else $error("push-out did not land on a bound edge");
  a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_YS) |=> (ys_r <= 13'd4096))
    else $error("sine magnitude out of range");
  a_cosine_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_YC) |=> (yc_r <= 13'd4096))
    else $error("cosine magnitude out of range");
  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FULL) |=> (res_slot == '0 && res_full))
    else $error("full table result carries a slot");
endmodule

FILE: design/rbtp_ctrl.sv
// ---------------------------------------------------------------------------
// rbtp_ctrl: box table sequencer
// Accepts commands, keeps the box count and steps the datapath through walks.
// ---------------------------------------------------------------------------
module rbtp_ctrl #(
  parameter int MAX_BOXES = rbtp_pkg::MAX_BOXES_DEF,
  parameter int AW        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
  parameter int CNT_W     = $clog2(MAX_BOXES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rbtp_pkg::KIND_W-1:0]  in_kind,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rbtp_pkg::dp_cmd_t            cmd,
  output logic [AW-1:0]                addr,
  input  rbtp_pkg::dp_stat_t           stat
);
  import rbtp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK, S_FIN, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;
  logic last_box, last_step;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign last_box  = (CNT_W'(idx_r) == count_r - CNT_W'(1));
  assign last_step = (kind_r == KIND_COLLIDE) ? (step_r == COL_LAST) : step_r[0];

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = OP_NONE;
    addr          = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          kind_nxt  = in_kind;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        idx_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DONE;
        case (kind_r)
          KIND_ADD: begin
            if (count_r == CNT_MAX) begin
              cmd.op = OP_FULL;
            end else begin
              cmd.op    = OP_ADD;
              addr      = AW'(count_r);
              count_nxt = count_r + CNT_W'(1);
            end
          end
          KIND_CLEAR: count_nxt = '0;
          KIND_TICK: if (count_r != '0) state_nxt = S_WALK;
          KIND_COLLIDE: state_nxt = (count_r != '0) ? S_WALK : S_FIN;
          KIND_ARM: cmd.op = OP_ARM;
          KIND_TRIG: begin
            cmd.op = OP_TRIG0;
            if (stat.fresh && count_r != '0) state_nxt = S_WALK;
          end
          default: ;
        endcase
        if (state_nxt == S_DONE) out_valid_nxt = 1'b1;
      end
      S_WALK: begin
        case (kind_r)
          KIND_COLLIDE: cmd.op = col_op(step_r);
          KIND_TICK:    cmd.op = step_r[0] ? OP_TICKW : OP_RD;
          default:      cmd.op = step_r[0] ? OP_TCHK : OP_RD;
        endcase
        if (last_step) begin
          step_nxt = '0;
          if (last_box) begin
            if (kind_r == KIND_COLLIDE) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt     = S_DONE;
              out_valid_nxt = 1'b1;
            end
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_FIN: begin
        cmd.op        = OP_OUTXY;
        state_nxt     = S_DONE;
        out_valid_nxt = 1'b1;
      end
      S_DONE: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("box count above table depth");
  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (CNT_W'(idx_r) < count_r))
    else $error("walk index past the filled table");
  a_valid_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_DONE))
    else $error("result shown outside the done state");
endmodule

FILE: sim/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for rotated_box_table_pushout
// Drives directed and random command words with bursty stalls on both channels, keeps its
// own copy of the box table, and checks every result word field by field.
// ---------------------------------------------------------------------------
module tb;
  import rbtp_pkg::*;

  typedef struct {
    logic [2:0]         kind;
    logic signed [23:0] px;
    logic signed [23:0] pz;
    logic [11:0]        ang;
    logic [13:0]        scl;
    logic [15:0]        rad;
    logic               held;
  } cmd_word_t;

  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] pz;
    logic [3:0]         slot;
    logic               full;
    logic               save;
  } res_word_t;

  // Table model and expected result store.
  class box_table_sb;
    longint bx[16];
    longint bz[16];
    int     bang[16];
    int     bscl[16];
    int     count;
    bit     was_held;
    longint hwid, hdep;
    res_word_t pending[$];
    int     errors;
    int     checked;

    function new();
      count = 0;
      was_held = 1;
      hwid = 0;
      hdep = 0;
      errors = 0;
      checked = 0;
    endfunction

    function longint sine_mag(int a);
      int v, sq, inner, y;
      v = (a - 1024) & 2047;
      if (v >= 1024) v -= 2048;
      sq = (v * v) >>> 6;
      inner = 19900 - ((sq * 3516) >>> 14);
      y = 4096 - ((sq * inner) >>> 16);
      return (y < 0) ? -y : y;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void note_command(cmd_word_t c);
      res_word_t r;
      longint cx, cz, hw, hd, cs, sn, bw, bd, lx, hx, lz, hz, pl, pr, pf, pb, m, dx, dz;
      bit fresh;
      r = '{px: 0, pz: 0, slot: 0, full: 0, save: 0};
      case (c.kind)
        KIND_ADD: begin
          if (count >= 16) r.full = 1'b1;
          else begin
            bx[count] = c.px;
            bz[count] = c.pz;
            bang[count] = c.ang;
            bscl[count] = c.scl;
            r.slot = count[3:0];
            count++;
          end
        end
        KIND_CLEAR: count = 0;
        KIND_TICK: for (int i = 0; i < count; i++) bang[i] = (bang[i] + 8) & 4095;
        KIND_COLLIDE: begin
          cx = c.px;
          cz = c.pz;
          for (int i = 0; i < count; i++) begin
            hw = (hwid * bscl[i]) >>> 12;
            hd = (hdep * bscl[i]) >>> 12;
            cs = sine_mag(bang[i] + 1024);
            sn = sine_mag(bang[i]);
            bw = (hw * cs + hd * sn) >>> 12;
            bd = (hw * sn + hd * cs) >>> 12;
            lx = bx[i] - bw - c.rad;
            hx = bx[i] + bw + c.rad;
            lz = bz[i] - bd - c.rad;
            hz = bz[i] + bd + c.rad;
            if (cx <= lx || cx >= hx || cz <= lz || cz >= hz) continue;
            pl = cx - lx; pr = hx - cx; pf = cz - lz; pb = hz - cz;
            m = pl; dx = -pl; dz = 0;
            if (pr < m) begin m = pr; dx = pr; dz = 0; end
            if (pf < m) begin m = pf; dx = 0; dz = -pf; end
            if (pb < m) begin dx = 0; dz = pb; end
            cx += dx;
            cz += dz;
          end
          r.px = cx[23:0];
          r.pz = cz[23:0];
        end
        KIND_ARM: was_held = c.held;
        KIND_TRIG: begin
          fresh = c.held && !was_held;
          was_held = c.held;
          if (fresh)
            for (int i = 0; i < count; i++)
              if (mag(c.px - bx[i]) + mag(c.pz - bz[i]) < 500) begin
                r.save = 1'b1;
                break;
              end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(res_word_t a);
      res_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.px !== e.px) begin
        $error("pushed_x exp %0d got %0d", e.px, a.px); errors++;
      end
      if (a.pz !== e.pz) begin
        $error("pushed_z exp %0d got %0d", e.pz, a.pz); errors++;
      end
      if (a.slot !== e.slot) begin
        $error("slot_index exp %0d got %0d", e.slot, a.slot); errors++;
      end
      if (a.full !== e.full) begin
        $error("table_full exp %0d got %0d", e.full, a.full); errors++;
      end
      if (a.save !== e.save) begin
        $error("save_requested exp %0d got %0d", e.save, a.save); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [HALF_W-1:0] cfg_data;
  rbtp_in_if  in_ch();
  rbtp_out_if out_ch();

  rotated_box_table_pushout u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  box_table_sb sb;
  bit quiet;          // no idling in the last part of the run
  bit long_hold;      // receiver holds off for a long stretch
  int sent;
  longint cycles;
  int adds, collides, triggers;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: random ready bursts, checks on the rising edge.
  initial begin
    res_word_t r;
    int n;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        r.px = out_ch.pushed_x;
        r.pz = out_ch.pushed_z;
        r.slot = out_ch.slot_index;
        r.full = out_ch.table_full;
        r.save = out_ch.save_requested;
        sb.check_result(r);
      end
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready = 0;
        repeat (400) @(negedge clk);
        long_hold = 0;
        out_ch.ready = 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 0;
        n = $urandom_range(1, 4);
        repeat (n - 1) @(negedge clk);
      end else out_ch.ready = 1;
    end
  end

  task automatic send_word(cmd_word_t c);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 0;
      n = $urandom_range(1, 4);
      repeat (n) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.kind = c.kind;
    in_ch.pos_x = c.px;
    in_ch.pos_z = c.pz;
    in_ch.angle = c.ang;
    in_ch.scale = c.scl;
    in_ch.radius = c.rad;
    in_ch.button_held = c.held;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(c);
    sent++;
    case (c.kind)
      KIND_ADD: adds++;
      KIND_COLLIDE: collides++;
      KIND_TRIG: triggers++;
      default: ;
    endcase
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // Registers change only while no command is in flight.
  task automatic write_reg(int idx, int val);
    while (sb.pending.size() != 0) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx[0];
    cfg_data = HALF_W'(val);
    @(negedge clk);
    cfg_we = 0;
    if (idx[0]) sb.hdep = cfg_data;
    else sb.hwid = cfg_data;
  endtask

  function automatic cmd_word_t mk(logic [2:0] k, int x, int z, int a, int s, int r, int h);
    cmd_word_t c;
    c.kind = k; c.px = 24'(x); c.pz = 24'(z); c.ang = 12'(a); c.scl = 14'(s);
    c.rad = 16'(r); c.held = h[0];
    return c;
  endfunction

  // Positions near a small cluster so collisions and triggers really happen.
  function automatic cmd_word_t rand_word(int spread);
    cmd_word_t c;
    int k;
    k = $urandom_range(0, 99);
    c.px = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    c.pz = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    if ($urandom_range(0, 19) == 0) begin
      c.px = 24'($urandom);
      c.pz = 24'($urandom);
    end
    c.ang = 12'($urandom);
    c.scl = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(2048, 8192));
    c.rad = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
    c.held = 1'($urandom);
    if (k < 22) c.kind = KIND_ADD;
    else if (k < 26) c.kind = KIND_CLEAR;
    else if (k < 34) c.kind = KIND_TICK;
    else if (k < 70) c.kind = KIND_COLLIDE;
    else if (k < 78) c.kind = KIND_ARM;
    else if (k < 96) c.kind = KIND_TRIG;
    else c.kind = 3'($urandom_range(6, 7));
    return c;
  endfunction

  initial begin
    sb = new();
    quiet = 0;
    long_hold = 0;
    sent = 0;
    adds = 0; collides = 0; triggers = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.kind = KIND_ADD;
    in_ch.pos_x = 0;
    in_ch.pos_z = 0;
    in_ch.angle = 0;
    in_ch.scale = 0;
    in_ch.radius = 0;
    in_ch.button_held = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;

    // Directed: collide and trigger on an empty table, then fill it up.
    send_word(mk(KIND_COLLIDE, 8388607, -8388608, 0, 0, 65535, 0));
    send_word(mk(KIND_TRIG, 0, 0, 0, 0, 0, 1));
    write_reg(0, 100);
    write_reg(1, 50);
    send_word(mk(KIND_ADD, 0, 0, 0, 4096, 0, 0));
    send_word(mk(KIND_ADD, -8388608, 8388607, 4095, 16383, 0, 0));
    send_word(mk(KIND_ADD, 300, 0, 1024, 4096, 0, 0));
    send_word(mk(KIND_ADD, 0, 300, 512, 0, 0, 0));
    // A point exactly on the expanded edge stays put.
    send_word(mk(KIND_COLLIDE, 110, 0, 0, 0, 10, 0));
    send_word(mk(KIND_COLLIDE, 5, 3, 0, 0, 20, 1));
    send_word(mk(KIND_COLLIDE, -8388600, 8388600, 0, 0, 65535, 0));
    send_word(mk(KIND_TICK, 0, 0, 0, 0, 0, 0));
    send_word(mk(KIND_ARM, 0, 0, 0, 0, 0, 0));
    send_word(mk(KIND_TRIG, 100, 100, 0, 0, 0, 1));
    send_word(mk(KIND_TRIG, 100, 100, 0, 0, 0, 1));
    send_word(mk(3'd6, 1, 1, 1, 1, 1, 1));
    send_word(mk(3'd7, -1, -1, 4095, 16383, 65535, 1));
    for (int i = 0; i < 13; i++) send_word(mk(KIND_ADD, i * 50, -i * 50, i * 300, 4096, 0, 0));
    send_word(mk(KIND_COLLIDE, 20, -20, 0, 0, 65535, 0));
    send_word(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases under different extents, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(0, 0); write_reg(1, 0); end
        1: begin write_reg(0, 32767); write_reg(1, 32767); end
        2: begin write_reg(0, 200); write_reg(1, 40); end
        default: begin write_reg(0, $urandom_range(0, 2000)); write_reg(1, $urandom); end
      endcase
      if (ph == 5) quiet = 1;
      for (int n = 0; n < 155; n++) begin
        if (ph == 1 && n == 20) long_hold = 1;
        if (ph == 2 && n == 50) while (sb.pending.size() != 0) @(negedge clk);
        send_word(rand_word((ph == 1) ? 40000 : 3000));
      end
      drain();
    end

    $display("Sent %0d command words (%0d adds, %0d collides, %0d triggers), checked %0d results.",
             sent, adds, collides, triggers, sb.checked);
    $display("Covered full table, edge contact, wraparound positions and six extent settings.");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
